@@ sv/dsrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star matcher package
// Command codes, pattern byte constants and the types shared by the matcher
// cells, the result queue and the top level.
// ----------------------------------------------------------------------------
package dsrm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  // Broadcast control that every cell sees in the same cycle.
  typedef struct packed {
    logic       step;     // a text byte advances the active positions
    logic       restart;  // active positions go back to position zero only
    logic [7:0] sym;      // text or pattern byte
  } cell_ctrl_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } result_t;

endpackage

@@ sv/dot_star_regex_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star regular expression matcher
// Whole-string matching of a byte stream against a pattern of literal bytes,
// '.' and '*', held in a row of element cells.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Payload            Direction
//   cmd       cmd_valid / cmd_stall       command, symbol    into the block
//   result    result_valid / result_stall matched, overflow  out of the block
//
// A new request may be taken in every cycle while cmd_stall is low. All element
// cells update their active position flags in parallel; the star closure
// ripples through the row combinationally like a carry chain.
// An end of text result is registered in the result queue, in the output
// register if it is free and otherwise in the skid stage.
// Reset (synchronous, active high) empties the pattern and the result queue.
// cmd_stall is high while both result slots are full, that is while the skid
// stage holds a result; it comes straight from a register.
// ----------------------------------------------------------------------------
module dot_star_regex_matcher #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] command,
  input  logic [7:0] symbol,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       matched,
  output logic       overflow
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  // Pattern bookkeeping: number of elements, whether the last element is
  // already starred, and whether the pattern has run out of cells.
  logic [CW-1:0] elem_count;
  logic [CW-1:0] elem_count_next;
  logic          last_starred;
  logic          last_starred_next;
  logic          pat_ovf;
  logic          pat_ovf_next;
  logic          tail_act;
  logic          tail_act_next;

  logic          accept;
  logic          new_elem;
  logic          star_op;
  logic          push;

  dsrm_pkg::cmd_t     cmd;
  dsrm_pkg::cell_ctrl_t ctrl;
  dsrm_pkg::result_t  res_in;
  dsrm_pkg::result_t  res_out;

  // Chains between neighbouring cells; index i feeds cell i.
  logic [MAX_ELEMENTS:0] carry;
  logic [MAX_ELEMENTS:0] adv;
  logic [MAX_ELEMENTS:0] closed_vec;

  assign accept = cmd_valid & ~cmd_stall;
  assign cmd    = dsrm_pkg::cmd_t'(command);

  // Decode the request. A '*' stars the previous element only when there is
  // one and it is not starred yet; otherwise it is a literal element.
  always_comb begin
    new_elem          = 1'b0;
    star_op           = 1'b0;
    push              = 1'b0;
    ctrl.step         = 1'b0;
    ctrl.restart      = 1'b0;
    ctrl.sym          = symbol;
    elem_count_next   = elem_count;
    last_starred_next = last_starred;
    pat_ovf_next      = pat_ovf;
    if (accept) begin
      unique case (cmd)
        dsrm_pkg::CMD_CLEAR: begin
          ctrl.restart    = 1'b1;
          elem_count_next = '0;
          pat_ovf_next    = 1'b0;
        end
        dsrm_pkg::CMD_APPEND: begin
          ctrl.restart = 1'b1;
          if (!pat_ovf) begin
            if (symbol == dsrm_pkg::STAR_BYTE && elem_count != '0 && !last_starred) begin
              star_op           = 1'b1;
              last_starred_next = 1'b1;
            end else if (elem_count == CW'(MAX_ELEMENTS)) begin
              pat_ovf_next = 1'b1;
            end else begin
              new_elem          = 1'b1;
              elem_count_next   = elem_count + CW'(1);
              last_starred_next = 1'b0;
            end
          end
        end
        dsrm_pkg::CMD_TEXT: begin
          ctrl.step = 1'b1;
        end
        dsrm_pkg::CMD_END: begin
          push         = 1'b1;
          ctrl.restart = 1'b1;
        end
        default: begin
          ctrl.step = 1'b0;
        end
      endcase
    end
  end

  assign carry[0] = 1'b0;
  assign adv[0]   = 1'b0;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    dsrm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .act_init  (i == 0),
      .in_use    (elem_count > CW'(i)),
      .wr_elem   (new_elem & (elem_count == CW'(i))),
      .set_star  (star_op & (elem_count == CW'(i + 1))),
      .carry_in  (carry[i]),
      .adv_in    (adv[i]),
      .carry_out (carry[i+1]),
      .adv_out   (adv[i+1]),
      .closed    (closed_vec[i])
    );
  end

  // The position past the last cell only ever becomes active by advancing.
  assign closed_vec[MAX_ELEMENTS] = tail_act | carry[MAX_ELEMENTS];

  always_comb begin
    if (ctrl.restart) begin
      tail_act_next = 1'b0;
    end else if (ctrl.step) begin
      tail_act_next = adv[MAX_ELEMENTS];
    end else begin
      tail_act_next = tail_act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count   <= '0;
      last_starred <= 1'b0;
      pat_ovf      <= 1'b0;
      tail_act     <= 1'b0;
    end else begin
      elem_count   <= elem_count_next;
      last_starred <= last_starred_next;
      pat_ovf      <= pat_ovf_next;
      tail_act     <= tail_act_next;
    end
  end

  // The whole pattern matched when the position after its last element is
  // live at end of text.
  assign res_in.matched  = closed_vec[elem_count] & ~pat_ovf;
  assign res_in.overflow = pat_ovf;

  dsrm_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (res_in),
    .full         (cmd_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (res_out)
  );

  assign matched  = res_out.matched;
  assign overflow = res_out.overflow;

endmodule

@@ sv/dsrm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star matcher cell
// Holds one pattern element and the active flag of its position, and passes
// the star closure and the advance of a match on to the next cell.
// ----------------------------------------------------------------------------
module dsrm_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  dsrm_pkg::cell_ctrl_t ctrl,
  input  logic                 act_init,
  input  logic                 in_use,
  input  logic                 wr_elem,
  input  logic                 set_star,
  input  logic                 carry_in,
  input  logic                 adv_in,
  output logic                 carry_out,
  output logic                 adv_out,
  output logic                 closed
);

  logic [7:0] elem_byte;
  logic       elem_any;
  logic       elem_starred;
  logic       act;
  logic       act_next;
  logic       hit;

  // A position is live if it is active or reached by skipping starred
  // elements to its left.
  assign closed    = act | carry_in;
  assign hit       = closed & in_use & (elem_any | (elem_byte == ctrl.sym));
  assign carry_out = closed & in_use & elem_starred;
  assign adv_out   = hit & ~elem_starred;

  always_comb begin
    if (ctrl.restart) begin
      act_next = act_init;
    end else if (ctrl.step) begin
      act_next = (hit & elem_starred) | adv_in;
    end else begin
      act_next = act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= act_init;
    end else begin
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_elem) begin
      elem_byte    <= ctrl.sym;
      elem_any     <= (ctrl.sym == dsrm_pkg::DOT_BYTE);
      elem_starred <= 1'b0;
    end else if (set_star) begin
      elem_starred <= 1'b1;
    end
  end

endmodule

@@ sv/dsrm_result_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star matcher result queue
// Two-entry output register with a skid stage, so that a request can be taken
// while a finished result still waits at the output.
// ----------------------------------------------------------------------------
module dsrm_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dsrm_pkg::result_t push_data,
  output logic              full,
  output logic              result_valid,
  input  logic              result_stall,
  output dsrm_pkg::result_t result_data
);

  logic              skid_valid;
  dsrm_pkg::result_t skid_data;
  logic              pop_free;

  assign pop_free = ~result_valid | ~result_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop_free) begin
      result_valid <= skid_valid | push;
      skid_valid   <= skid_valid & push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_free) begin
      if (skid_valid) begin
        result_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        result_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

@@ test/dot_star_regex_matcher_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star matcher testbench
// Loads patterns of literal bytes, '.' and '*' into the matcher, streams text
// through it and compares every end-of-text verdict with a position-set
// prediction kept alongside. Both handshakes idle and stall in random bursts.
// ----------------------------------------------------------------------------
module dot_star_regex_matcher_test;

  localparam int NUM_ELEMENTS = 32;
  localparam int ITEM_TARGET  = 1500;
  // The last stretch of requests runs with no idling on either side.
  localparam int CALM_FROM    = 1250;
  // Worst case is about ITEM_TARGET requests, each with the longest idle gap and
  // a stall, so this leaves a wide margin.
  localparam int CYCLE_LIMIT  = 300000;

  // Predicts the matched and overflow flags of each end of text request and
  // holds them until the block hands the verdict over.
  class match_scoreboard;
    logic [7:0]            elem_byte [NUM_ELEMENTS];
    logic                  elem_any  [NUM_ELEMENTS];
    logic                  elem_star [NUM_ELEMENTS];
    int unsigned           elem_count;
    logic [NUM_ELEMENTS:0] live;
    logic                  pat_ovf;
    dsrm_pkg::result_t     awaited [$];
    int                    errors;

    function new();
      elem_count = 0;
      live       = 1;
      pat_ovf    = 1'b0;
      errors     = 0;
    endfunction

    // Adds every position that can be reached by skipping starred elements.
    // The loop runs upwards so a run of starred elements is crossed in one go.
    function logic [NUM_ELEMENTS:0] close_set(logic [NUM_ELEMENTS:0] s);
      for (int i = 0; i < elem_count; i++) begin
        if (s[i] && elem_star[i]) s[i+1] = 1'b1;
      end
      return s;
    endfunction

    function void note_request(dsrm_pkg::cmd_t cmd, logic [7:0] sym);
      logic [NUM_ELEMENTS:0] cur;
      logic [NUM_ELEMENTS:0] nxt;
      dsrm_pkg::result_t     verdict;
      case (cmd)
        dsrm_pkg::CMD_CLEAR: begin
          elem_count = 0;
          pat_ovf    = 1'b0;
          live       = 1;
        end
        dsrm_pkg::CMD_APPEND: begin
          live = 1;
          if (!pat_ovf) begin
            if (sym == dsrm_pkg::STAR_BYTE && elem_count > 0 &&
                !elem_star[elem_count-1]) begin
              elem_star[elem_count-1] = 1'b1;
            end else if (elem_count >= NUM_ELEMENTS) begin
              pat_ovf = 1'b1;
            end else begin
              elem_byte[elem_count] = sym;
              elem_any[elem_count]  = (sym == dsrm_pkg::DOT_BYTE);
              elem_star[elem_count] = 1'b0;
              elem_count++;
            end
          end
        end
        dsrm_pkg::CMD_TEXT: begin
          cur = close_set(live);
          nxt = '0;
          for (int i = 0; i < elem_count; i++) begin
            if (cur[i] && (elem_any[i] || elem_byte[i] == sym)) begin
              if (elem_star[i]) nxt[i] = 1'b1;
              else nxt[i+1] = 1'b1;
            end
          end
          live = nxt;
        end
        default: begin
          cur              = close_set(live);
          verdict.matched  = cur[elem_count] && !pat_ovf;
          verdict.overflow = pat_ovf;
          awaited.push_back(verdict);
          live = 1;
        end
      endcase
    endfunction

    function void check_result(logic m, logic o);
      dsrm_pkg::result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, got matched %0b overflow %0b",
                 $time, m, o);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (m !== want.matched) begin
        $display("%0t: matched mismatch, expected %0b, got %0b", $time, want.matched, m);
        errors++;
      end
      if (o !== want.overflow) begin
        $display("%0t: overflow mismatch, expected %0b, got %0b", $time, want.overflow, o);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  logic [1:0] command;
  logic [7:0] symbol;
  logic       result_valid;
  logic       result_stall;
  logic       matched;
  logic       overflow;

  match_scoreboard sb = new();
  int  sent_count;
  int  cycle_count;
  // When low, neither side inserts idle cycles or stalls.
  bit  idle_on;

  dot_star_regex_matcher #(
    .MAX_ELEMENTS(NUM_ELEMENTS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .command     (command),
    .symbol      (symbol),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .matched     (matched),
    .overflow    (overflow)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Watchdog: a hung handshake or a lost verdict ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Verdicts are sampled at the rising edge, where the handshake completes.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(matched, overflow);
  end

  // The result side stalls in random bursts. It changes only at the falling
  // edge, so exactly one value is assigned per time step.
  initial begin
    int len;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && idle_on && $urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 5);
        result_stall <= 1'b1;
        repeat (len) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Presents one request, possibly after an idle burst, and holds it steady
  // until the block takes it. Always entered and left at a falling edge, so
  // the valid line is assigned at most once in any time step.
  task automatic send_request(dsrm_pkg::cmd_t cmd, logic [7:0] sym);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= cmd;
    symbol    <= sym;
    do @(posedge clk); while (cmd_stall);
    sb.note_request(cmd, sym);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_string(dsrm_pkg::cmd_t cmd, string s);
    for (int i = 0; i < s.len(); i++) send_request(cmd, s[i]);
  endtask

  initial begin
    logic [7:0] txt [$];
    logic [7:0] b;
    int         plen;
    int         reps;
    int         texts;
    int         pick;

    rst          = 1'b1;
    cmd_valid    = 1'b0;
    command      = dsrm_pkg::CMD_CLEAR;
    symbol       = 8'h00;
    idle_on      = 1'b0;
    sent_count   = 0;
    cycle_count  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- Directed requests ----
    // Empty pattern against empty text straight after reset must match.
    send_request(dsrm_pkg::CMD_END, 8'hFF);
    // A single starred element still matches the empty text.
    send_request(dsrm_pkg::CMD_CLEAR, 8'hFF);
    send_string(dsrm_pkg::CMD_APPEND, "a*");
    send_request(dsrm_pkg::CMD_END, 8'h00);
    // A leading star has nothing to star, so it becomes a literal element;
    // a second star after a starred element is likewise literal.
    send_request(dsrm_pkg::CMD_CLEAR, 8'h00);
    send_string(dsrm_pkg::CMD_APPEND, "*b**");
    send_string(dsrm_pkg::CMD_TEXT, "*bbb*");
    send_request(dsrm_pkg::CMD_END, 8'h55);
    // Dot-star followed by a zero byte element; zero and all-ones text bytes.
    send_request(dsrm_pkg::CMD_CLEAR, 8'hAA);
    send_request(dsrm_pkg::CMD_APPEND, dsrm_pkg::DOT_BYTE);
    send_request(dsrm_pkg::CMD_APPEND, dsrm_pkg::STAR_BYTE);
    send_request(dsrm_pkg::CMD_APPEND, 8'h00);
    send_request(dsrm_pkg::CMD_TEXT, 8'hFF);
    send_request(dsrm_pkg::CMD_TEXT, 8'h00);
    // A pattern byte in the middle of the text abandons the partial text.
    send_request(dsrm_pkg::CMD_APPEND, 8'hFF);
    send_request(dsrm_pkg::CMD_TEXT, 8'h00);
    send_request(dsrm_pkg::CMD_TEXT, 8'hFF);
    send_request(dsrm_pkg::CMD_END, 8'hFF);
    // Filling the element row, then one more element and a star: both are
    // dropped and the verdict reports overflow even for matching text.
    send_request(dsrm_pkg::CMD_CLEAR, 8'h00);
    for (int i = 0; i < NUM_ELEMENTS + 1; i++) begin
      send_request(dsrm_pkg::CMD_APPEND, dsrm_pkg::DOT_BYTE);
    end
    send_request(dsrm_pkg::CMD_APPEND, dsrm_pkg::STAR_BYTE);
    for (int i = 0; i < NUM_ELEMENTS; i++) send_request(dsrm_pkg::CMD_TEXT, 8'h41);
    send_request(dsrm_pkg::CMD_END, 8'h00);

    // ---- Random requests ----
    // Mostly well-formed sequences: a fresh pattern drawn from a small
    // alphabet so stars and dots are common, then texts built from the stored
    // elements so that a fair share match, some with a deliberate flaw.
    while (sent_count < ITEM_TARGET) begin
      idle_on = (sent_count < CALM_FROM) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        // Noise: any command with any byte.
        repeat ($urandom_range(1, 6))
          send_request(dsrm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        continue;
      end
      send_request(dsrm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
      // Most patterns are short; a few are long enough to overflow the row.
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
      for (int i = 0; i < plen; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 8)       b = (pick < 4) ? "a" : "b";
        else if (pick < 12) b = dsrm_pkg::DOT_BYTE;
        else if (pick < 17) b = dsrm_pkg::STAR_BYTE;
        else                b = 8'($urandom_range(0, 255));
        send_request(dsrm_pkg::CMD_APPEND, b);
      end
      texts = $urandom_range(1, 4);
      repeat (texts) begin
        txt.delete();
        for (int i = 0; i < sb.elem_count; i++) begin
          reps = sb.elem_star[i] ? $urandom_range(0, 3) : 1;
          repeat (reps) begin
            if (!sb.elem_any[i]) b = sb.elem_byte[i];
            else if ($urandom_range(0, 1) == 0) b = "a";
            else b = 8'($urandom_range(0, 255));
            txt.push_back(b);
          end
        end
        // Three texts in eight get a corrupted, missing or extra byte.
        case ($urandom_range(0, 7))
          0: if (txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
          1: if (txt.size() > 0) txt.delete($urandom_range(0, txt.size() - 1));
          default: if ($urandom_range(0, 5) == 0) txt.push_back(8'($urandom_range(0, 255)));
        endcase
        foreach (txt[i]) begin
          // Now and then a pattern byte lands in the middle of the text.
          if ($urandom_range(0, 60) == 0) send_request(dsrm_pkg::CMD_APPEND, "b");
          send_request(dsrm_pkg::CMD_TEXT, txt[i]);
        end
        send_request(dsrm_pkg::CMD_END, 8'($urandom_range(0, 255)));
      end
    end

    // ---- Drain ----
    idle_on = 1'b0;
    cmd_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    // Then wait on, so that any verdict the block might still emit is caught.
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
